FILE: sv/display_init_list_interpreter_top_assert.svh
// Assertion macros shared by the dili_front and dili_queue modules.
`ifndef DISPLAY_INIT_LIST_INTERPRETER_TOP_ASSERT_SVH
`define DISPLAY_INIT_LIST_INTERPRETER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DILI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DILI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dili_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dili_pkg;

  localparam logic [7:0] MASK_RESET      = 8'd128;
  localparam logic [7:0] DELAY_LONG_CODE = 8'd255;
  localparam logic [8:0] DELAY_LONG_MS   = 9'd500;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_OPCODE,
    PH_ARGCNT,
    PH_ARG,
    PH_DELAY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD,
    KIND_DATA,
    KIND_DELAY,
    KIND_END
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } front_item_t;

endpackage

`default_nettype wire

FILE: sv/dili_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "display_init_list_interpreter_top_assert.svh"

module dili_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         list_byte,
  input  wire logic [7:0]         mask,
  output logic                    push,
  output dili_pkg::front_item_t   item
);
  import dili_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] commands_left;
  logic [7:0] commands_left_next;
  logic [7:0] args_left;
  logic [7:0] args_left_next;
  logic       delay_pending;
  logic       delay_pending_next;

  logic       delay_flag;
  logic [7:0] arg_count;
  logic       last_cmd;
  logic       last_arg;

  assign delay_flag = |(list_byte & mask);
  assign arg_count  = list_byte & ~mask;
  assign last_cmd   = (commands_left == 8'd1);
  assign last_arg   = (args_left == 8'd1);

  always_comb begin
    phase_next         = phase;
    commands_left_next = commands_left;
    args_left_next     = args_left;
    delay_pending_next = delay_pending;
    if (accept) begin
      unique case (phase)
        PH_COUNT: begin
          commands_left_next = list_byte;
          args_left_next     = 8'd0;
          delay_pending_next = 1'b0;
          phase_next         = (list_byte == 8'd0) ? PH_COUNT : PH_OPCODE;
        end
        PH_OPCODE: begin
          phase_next = PH_ARGCNT;
        end
        PH_ARGCNT: begin
          delay_pending_next = delay_flag;
          args_left_next     = arg_count;
          if (arg_count != 8'd0) begin
            phase_next = PH_ARG;
          end else if (delay_flag) begin
            phase_next = PH_DELAY;
          end else begin
            commands_left_next = commands_left - 8'd1;
            phase_next         = last_cmd ? PH_COUNT : PH_OPCODE;
          end
        end
        PH_ARG: begin
          args_left_next = args_left - 8'd1;
          if (last_arg) begin
            if (delay_pending) begin
              phase_next = PH_DELAY;
            end else begin
              commands_left_next = commands_left - 8'd1;
              phase_next         = last_cmd ? PH_COUNT : PH_OPCODE;
            end
          end
        end
        PH_DELAY: begin
          delay_pending_next = 1'b0;
          commands_left_next = commands_left - 8'd1;
          phase_next         = last_cmd ? PH_COUNT : PH_OPCODE;
        end
        default: begin
          phase_next = PH_COUNT;
        end
      endcase
    end
  end

  always_comb begin
    push       = 1'b0;
    item.kind  = KIND_END;
    item.value = 8'd0;
    item.last  = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_COUNT: begin
          push      = (list_byte == 8'd0);
          item.last = 1'b1;
        end
        PH_OPCODE: begin
          push       = 1'b1;
          item.kind  = KIND_CMD;
          item.value = list_byte;
        end
        PH_ARGCNT: begin
          push      = (arg_count == 8'd0) && !delay_flag && last_cmd;
          item.last = 1'b1;
        end
        PH_ARG: begin
          push       = 1'b1;
          item.kind  = KIND_DATA;
          item.value = list_byte;
          item.last  = last_arg && !delay_pending && last_cmd;
        end
        PH_DELAY: begin
          push       = 1'b1;
          item.kind  = KIND_DELAY;
          item.value = list_byte;
          item.last  = last_cmd;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COUNT;
      commands_left <= 8'd0;
      args_left     <= 8'd0;
      delay_pending <= 1'b0;
    end else begin
      phase         <= phase_next;
      commands_left <= commands_left_next;
      args_left     <= args_left_next;
      delay_pending <= delay_pending_next;
    end
  end

  `DILI_ASSERT_NEXT(a_last_returns_to_count, clk, rst, push && item.last,
    phase == PH_COUNT, "A list-ending transfer did not return to the count phase.")
  `DILI_ASSERT_SAME(a_end_marker_form, clk, rst, push && item.kind == KIND_END,
    item.last && item.value == 8'd0, "An end marker lacks list_end or has a nonzero value.")
  `DILI_ASSERT_SAME(a_opcode_emits_cmd, clk, rst, accept && phase == PH_OPCODE,
    push && item.kind == KIND_CMD, "An opcode byte did not produce a command transfer.")

endmodule

`default_nettype wire

FILE: sv/dili_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "display_init_list_interpreter_top_assert.svh"

module dili_queue #(
  parameter int unsigned DEPTH = dili_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire dili_pkg::front_item_t push_item,
  input  wire logic                  pop,
  output dili_pkg::front_item_t      head_item,
  output logic                       empty,
  output logic                       full
);
  import dili_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  front_item_t   store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty     = (count == CW'(0));
  assign full      = (count == CW'(DEPTH));
  assign head_item = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `DILI_ASSERT_SAME(a_no_push_when_full, clk, rst, push, !full,
    "A transfer was pushed into a full queue.")
  `DILI_ASSERT_SAME(a_no_pop_when_empty, clk, rst, pop, !empty,
    "A transfer was popped from an empty queue.")

endmodule

`default_nettype wire

FILE: sv/dili_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dili_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire dili_pkg::front_item_t q_item,
  output logic                       pop,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [1:0]                 out_kind,
  output logic [8:0]                 out_value,
  output logic                       list_end
);
  import dili_pkg::*;

  logic [8:0] value_next;

  assign pop = !q_empty && (!result_valid || !result_stall);

  always_comb begin
    if (q_item.kind == KIND_DELAY && q_item.value == DELAY_LONG_CODE) begin
      value_next = DELAY_LONG_MS;
    end else begin
      value_next = {1'b0, q_item.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind  <= q_item.kind;
      out_value <= value_next;
      list_end  <= q_item.last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/display_init_list_interpreter_top.sv
// Each transfer is queued, then registered in the output stage with result_valid.
// One list byte per cycle while list_stall is low, including bytes that emit nothing.
// The two-entry queue between decoder and output stage sets when list_stall rises.
// Reset clears the decoder to expect a count byte, empties the queue,
// drops result_valid and sets the delay flag mask to 128.
`timescale 1ns / 1ps
`default_nettype none

module display_init_list_interpreter_top #(
  parameter int unsigned QUEUE_DEPTH = dili_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       list_valid,
  output logic            list_stall,
  input  wire logic [7:0] list_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [1:0]      out_kind,
  output logic [8:0]      out_value,
  output logic            list_end
);
  import dili_pkg::*;

  logic        delay_flag_mask;
  logic [7:0]  mask;
  logic        accept;
  logic        push;
  front_item_t push_item;
  front_item_t head_item;
  logic        q_empty;
  logic        q_full;
  logic        pop;

  assign cfg_ready       = 1'b1;
  assign delay_flag_mask = cfg_valid && cfg_ready;
  assign list_stall      = q_full;
  assign accept          = list_valid && !list_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= MASK_RESET;
    end else if (delay_flag_mask) begin
      mask <= cfg_data;
    end
  end

  dili_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .list_byte (list_byte),
    .mask      (mask),
    .push      (push),
    .item      (push_item)
  );

  dili_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  dili_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_item       (head_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .list_end     (list_end)
  );

endmodule

`default_nettype wire

FILE: verif/tb_display_init_list_interpreter_top.sv
`timescale 1ns / 1ps

module tb_display_init_list_interpreter_top;
  import dili_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    kind_t      kind;
    logic [8:0] value;
    logic       last;
  } link_op_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic       list_valid = 1'b0;
  logic       list_stall;
  logic [7:0] list_byte = 8'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] out_kind;
  logic [8:0] out_value;
  logic       list_end;

  display_init_list_interpreter_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .list_valid  (list_valid),
    .list_stall  (list_stall),
    .list_byte   (list_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .list_end    (list_end)
  );

  link_op_t   expected_link_ops[$];
  phase_t     list_phase = PH_COUNT;
  logic [7:0] cmds_remaining = 8'd0;
  logic [7:0] args_remaining = 8'd0;
  logic       delay_owed = 1'b0;
  logic [7:0] flag_mask = MASK_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int ops_checked = 0;
  int lists_done = 0;
  int mask_writes = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("cycle %0d: %s", cycle_count, what);
    end
  endtask

  always @(posedge clk) begin : check_link_ops
    link_op_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_link_ops.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer kind %0d value %0d end %0d",
                                  out_kind, out_value, list_end));
      end else begin
        want = expected_link_ops.pop_front();
        ops_checked++;
        if (out_kind !== want.kind || out_value !== want.value || list_end !== want.last) begin
          report_mismatch($sformatf(
              "expected kind %0d value %0d end %0d, got kind %0d value %0d end %0d",
              want.kind, want.value, want.last, out_kind, out_value, list_end));
        end
      end
    end
  end

  function automatic logic retire_command();
    cmds_remaining = cmds_remaining - 8'd1;
    if (cmds_remaining == 8'd0) begin
      list_phase = PH_COUNT;
      return 1'b1;
    end
    list_phase = PH_OPCODE;
    return 1'b0;
  endfunction

  task automatic interpret_list_byte(input logic [7:0] b);
    link_op_t op;
    logic     produced;
    logic     done;
    produced = 1'b0;
    case (list_phase)
      PH_OPCODE: begin
        op = '{kind: KIND_CMD, value: {1'b0, b}, last: 1'b0};
        produced = 1'b1;
        list_phase = PH_ARGCNT;
      end
      PH_ARGCNT: begin
        delay_owed = (b & flag_mask) != 8'd0;
        args_remaining = b & ~flag_mask;
        if (args_remaining != 8'd0) begin
          list_phase = PH_ARG;
        end else if (delay_owed) begin
          list_phase = PH_DELAY;
        end else if (retire_command()) begin
          op = '{kind: KIND_END, value: 9'd0, last: 1'b1};
          produced = 1'b1;
        end
      end
      PH_ARG: begin
        args_remaining = args_remaining - 8'd1;
        done = 1'b0;
        if (args_remaining == 8'd0) begin
          if (delay_owed) list_phase = PH_DELAY;
          else done = retire_command();
        end
        op = '{kind: KIND_DATA, value: {1'b0, b}, last: done};
        produced = 1'b1;
      end
      PH_DELAY: begin
        delay_owed = 1'b0;
        done = retire_command();
        op = '{kind: KIND_DELAY, value: (b == DELAY_LONG_CODE) ? DELAY_LONG_MS : {1'b0, b},
               last: done};
        produced = 1'b1;
      end
      default: begin
        cmds_remaining = b;
        args_remaining = 8'd0;
        delay_owed = 1'b0;
        if (b == 8'd0) begin
          list_phase = PH_COUNT;
          op = '{kind: KIND_END, value: 9'd0, last: 1'b1};
          produced = 1'b1;
        end else begin
          list_phase = PH_OPCODE;
        end
      end
    endcase
    if (produced) begin
      expected_link_ops.push_back(op);
      if (op.last) lists_done++;
    end
  endtask

  task automatic send_list_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      list_valid <= 1'b0;
      @(negedge clk);
    end
    list_valid <= 1'b1;
    list_byte <= b;
    do @(posedge clk); while (list_stall);
    bytes_sent++;
    interpret_list_byte(b);
  endtask

  task automatic send_list(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_list_byte(bytes[i]);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    list_valid <= 1'b0;
    while (expected_link_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_flag_mask(input logic [7:0] m);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    flag_mask = m;
    mask_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_list_byte(input bit noise);
    logic [7:0] args;
    logic [7:0] flags;
    logic [7:0] r;
    r = 8'($urandom);
    if (noise && list_phase != PH_COUNT) return r;
    case (list_phase)
      PH_COUNT: return ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
      PH_ARGCNT: begin
        args = 8'($urandom_range(0, 3)) & ~flag_mask;
        flags = $urandom_range(1) ? (r & flag_mask) : 8'd0;
        return args | flags;
      end
      PH_DELAY: return ($urandom_range(3) == 0) ? DELAY_LONG_CODE : r;
      default: return r;
    endcase
  endfunction

  task automatic finish_open_list();
    while (list_phase != PH_COUNT) send_list_byte(pick_list_byte(1'b0));
  endtask

  task automatic test_basic_lists();
    send_list('{8'd0});
    send_list('{8'd2, 8'h00, 8'h02, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF});
    send_list('{8'd1, 8'h5A, 8'h81, 8'hA5, 8'hFE});
    send_list('{8'd1, 8'hC3, 8'h00});
    wait_quiet();
  endtask

  task automatic test_mask_settings();
    write_flag_mask(8'h03);
    send_list('{8'd1, 8'h11, 8'h06, 8'h01, 8'h02, 8'h04, 8'h08, 8'hFF});
    write_flag_mask(8'h00);
    send_list('{8'd1, 8'h22, 8'h02, 8'h7F, 8'h80});
    write_flag_mask(8'hFF);
    send_list('{8'd1, 8'h33, 8'h01, 8'h00});
    write_flag_mask(8'h01);
    send_list('{8'd1, 8'h44, 8'h80, 8'hAA});
    wait_quiet();
  endtask

  task automatic test_config_mid_list();
    write_flag_mask(MASK_RESET);
    send_list('{8'd2, 8'h55});
    write_flag_mask(8'h01);
    send_list('{8'h03, 8'h12, 8'h34, 8'h0A, 8'h66, 8'h00});
    wait_quiet();
  endtask

  task automatic test_backpressure();
    wait_quiet();
    hold_cycles = 120;
    send_idle_pct = 0;
    repeat (60) send_list_byte(pick_list_byte(1'b0));
    finish_open_list();
    wait_quiet();
  endtask

  task automatic test_random_lists(input int s_pct, input int r_pct, input logic [7:0] m,
                                   input int n);
    write_flag_mask(m);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_list_byte(pick_list_byte($urandom_range(99) < 4));
    finish_open_list();
    wait_quiet();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 61;
    test_basic_lists();
    test_mask_settings();
    test_config_mid_list();
    test_random_lists(6, 61, 8'h01, 230);
    test_backpressure();
    test_random_lists(61, 6, 8'hFF, 230);
    test_random_lists(0, 0, 8'($urandom_range(1, 255)), 230);
    test_random_lists(0, 0, MASK_RESET, 40);
    wait_quiet();
    if (expected_link_ops.size() != 0) report_mismatch("results still outstanding");
    $display("Sent %0d list bytes over %0d lists; checked %0d link transfers.",
             bytes_sent, lists_done, ops_checked);
    $display("Wrote the delay flag mask %0d times; %0d mismatches.", mask_writes, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: display_init_list_interpreter_top.f
+incdir+sv
sv/dili_pkg.sv
sv/dili_front.sv
sv/dili_queue.sv
sv/dili_back.sv
sv/display_init_list_interpreter_top.sv
verif/tb_display_init_list_interpreter_top.sv
